### sv/cnnr_pkg.sv
package cnnr_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int COST_BITS_DEF = 16;
  localparam int MAX_RESULTS   = 64;
  localparam int SUM_BITS      = 21;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
  localparam logic [11:0] CAP_RESET   = 12'd15;
  localparam logic [4:0]  COUNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_DIST = 2'd0,
    OP_DEM  = 2'd1,
    OP_RUN  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [0:0] REG_CAP   = 1'b0;
  localparam logic [0:0] REG_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPEN,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_APPEND,
    ST_CLOSE,
    ST_COST,
    ST_COST_LAST,
    ST_EMIT,
    ST_TOTAL,
    ST_DONE
  } state_t;

endpackage

### sv/capacitated_nearest_neighbour_routes_core.sv
// Capacitated nearest-neighbor route builder.
// Input channel (in_valid/in_ready): operation 0 writes a distance entry
// (from_node, to_node, value), operation 1 writes the demand of from_node
// (low 8 bits of value), operation 2 runs the greedy route builder,
// operation 3 is ignored. Load beats are taken one per cycle when idle and not clearing.
// A run beat walks the matrix from a synchronous 1-read memory: each route
// extension scans all customers at one read per cycle, each route is
// re-walked edge by edge to sum its cost, and a kept route is then emitted
// node by node.
// Result channel (out_valid/out_ready): route nodes in visit order, the
// closing depot node carries route_end and route_cost; a summary beat with
// is_total and total_cost ends every run. At most 63 route beats per run.
// The output register holds a beat until taken; emitting stalls while a
// beat waits, and no input beat is taken while a run is in progress.
// Reset (rst_n, synchronous) clears the distance matrix by a sweep over all
// 2**(2*clog2(MAX_NODES)) entries (256 by default) with in_ready low;
// demands, capacity (15) and node count (16) reset at once. Configuration
// goes through the APB-style cfg_ port: capacity at 0x0, node count at 0x4.
module capacitated_nearest_neighbour_routes_core
  import cnnr_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int COST_BITS = COST_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  logic [3:0]          in_from_node,
  input  logic [3:0]          in_to_node,
  input  logic [15:0]         in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_node,
  output logic [SUM_BITS-1:0] out_route_cost,
  output logic                out_route_end,
  output logic [SUM_BITS-1:0] out_total_cost,
  output logic                out_is_total,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int NB  = $clog2(MAX_NODES);
  localparam int AB  = 2 * NB;
  localparam int LB  = $clog2(MAX_NODES + 2);
  localparam int RB  = $clog2(MAX_RESULTS);
  localparam int CB  = (COST_BITS < 16) ? COST_BITS : 16;
  localparam logic [LB-1:0] MAXN_L = LB'(MAX_NODES);

  // configuration
  logic [11:0] cap_r;
  logic [4:0]  count_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      count_r <= COUNT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_CAP && cfg_paddr[1:0] == 2'd0) begin
      cap_r <= cfg_pwdata[11:0];
    end else if (cfg_wr && cfg_paddr[2] == REG_COUNT && cfg_paddr[1:0] == 2'd0) begin
      count_r <= cfg_pwdata[4:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_CAP) cfg_prdata[11:0] = cap_r;
    else                         cfg_prdata[4:0]  = count_r;
  end

  // effective node count, saturated
  logic [LB-1:0] n_eff;
  always_comb begin
    if (int'(count_r) > MAX_NODES) n_eff = MAXN_L;
    else                           n_eff = LB'(count_r);
  end

  // storage
  logic [CB-1:0] dist_mem [MAX_NODES*MAX_NODES];
  logic [CB-1:0] dist_rd;
  logic [NB-1:0] route_mem [MAX_NODES+1];
  logic [NB-1:0] route_rd;
  logic [7:0]    dem_r [MAX_NODES];
  logic [MAX_NODES-1:0] visited_r, visited_nxt;

  state_t state_r, state_nxt;
  logic [AB:0]    clr_r;
  logic           clr_busy;
  logic [LB-1:0]  cust_r, cust_nxt;     // route opening scan index
  logic [LB-1:0]  j_r, j_nxt;           // candidate index
  logic [LB-1:0]  len_r, len_nxt;
  logic [LB-1:0]  k_r, k_nxt;
  logic [NB-1:0]  last_r, last_nxt;
  logic [12:0]    load_r, load_nxt;
  logic           found_r, found_nxt;
  logic [NB-1:0]  best_r, best_nxt;
  logic [CB-1:0]  bestd_r, bestd_nxt;
  logic [NB-1:0]  pj_r, pj_nxt;         // candidate whose read is in flight
  logic           pv_r, pv_nxt;         // pending candidate passes filters
  logic [SUM_BITS-1:0] rcost_r, rcost_nxt, total_r, total_nxt;
  logic           ok_r, ok_nxt;
  logic [RB-1:0]  cnt_r, cnt_nxt;
  logic [NB-1:0]  prev_r, prev_nxt;     // previous node in cost walk

  // memory ports
  logic           dist_we;
  logic [AB-1:0]  dist_wa, dist_ra;
  logic [CB-1:0]  dist_wd;
  logic           rt_we;
  logic [LB-1:0]  rt_wa, rt_ra;
  logic [NB-1:0]  rt_wd;

  // output register
  logic           ov_r;
  logic [3:0]     on_r;
  logic [SUM_BITS-1:0] orc_r, otc_r;
  logic           ore_r, oit_r;
  logic           o_load;
  logic [3:0]     o_node;
  logic [SUM_BITS-1:0] o_rc, o_tc;
  logic           o_re, o_it;
  logic           o_free;

  assign clr_busy = !clr_r[AB];
  assign o_free   = !ov_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && !clr_busy;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (dist_we) dist_mem[dist_wa] <= dist_wd;
    dist_rd <= dist_mem[dist_ra];
  end
  always_ff @(posedge clk) begin
    if (rt_we) route_mem[rt_wa] <= rt_wd;
    route_rd <= route_mem[rt_ra];
  end

  // demand table, small, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) dem_r[i] <= '0;
    end else if (in_acc && op_t'(in_operation) == OP_DEM &&
                 int'(in_from_node) < MAX_NODES) begin
      dem_r[NB'(in_from_node)] <= in_value[7:0];
    end
  end

  // candidate filter for the index being read this cycle
  logic [NB-1:0] jn;
  logic          cand_ok;
  assign jn = NB'(j_r);
  assign cand_ok = !visited_r[jn] &&
                   ({1'b0, load_r} + 14'(dem_r[jn]) <= {2'b0, cap_r});

  // route opening: customer index and whether it starts a route
  logic [NB-1:0] cn;
  logic          open_go;
  assign cn = NB'(cust_r);
  assign open_go = (cust_r < n_eff) && !visited_r[cn] && (cn != '0);

  // emit ends after the closing depot or at the result limit
  logic emit_stop;
  assign emit_stop = (k_r >= len_r) || (cnt_r == RB'(MAX_RESULTS-1));

  // cost walk saturating add
  logic [SUM_BITS:0] radd;
  assign radd = {1'b0, rcost_r} + (SUM_BITS+1)'(dist_rd);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_acc && op_t'(in_operation) == OP_RUN) state_nxt = ST_OPEN;
      ST_OPEN: begin
        if (cust_r >= n_eff || n_eff < LB'(2)) state_nxt = ST_TOTAL;
        else if (open_go)                      state_nxt = ST_SCAN;
      end
      ST_SCAN:      if (j_r >= n_eff - LB'(1)) state_nxt = ST_SCAN_LAST;
      ST_SCAN_LAST: state_nxt = ST_APPEND;
      ST_APPEND: begin
        if (found_r && len_r < MAXN_L) state_nxt = ST_SCAN;
        else                           state_nxt = ST_CLOSE;
      end
      ST_CLOSE:     state_nxt = ST_COST;
      ST_COST:      if (k_r >= len_r - LB'(1)) state_nxt = ST_COST_LAST;
      ST_COST_LAST: state_nxt = ok_nxt ? ST_EMIT : ST_OPEN;
      ST_EMIT:      if (emit_stop) state_nxt = ST_OPEN;
      ST_TOTAL:     if (o_free) state_nxt = ST_DONE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    visited_nxt = visited_r;
    cust_nxt = cust_r; j_nxt = j_r; len_nxt = len_r; k_nxt = k_r;
    last_nxt = last_r; load_nxt = load_r; found_nxt = found_r;
    best_nxt = best_r; bestd_nxt = bestd_r; pj_nxt = pj_r; pv_nxt = pv_r;
    rcost_nxt = rcost_r; total_nxt = total_r; ok_nxt = ok_r; cnt_nxt = cnt_r;
    prev_nxt = prev_r;
    dist_we = 1'b0; dist_wa = '0; dist_wd = '0; dist_ra = '0;
    rt_we = 1'b0; rt_wa = '0; rt_wd = '0; rt_ra = '0;
    o_load = 1'b0; o_node = '0; o_rc = '0; o_tc = '0; o_re = 1'b0; o_it = 1'b0;

    if (clr_busy) begin
      dist_we = 1'b1;
      dist_wa = clr_r[AB-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && op_t'(in_operation) == OP_DIST &&
            int'(in_from_node) < MAX_NODES &&
            int'(in_to_node) < MAX_NODES) begin
          dist_we = 1'b1;
          dist_wa = {NB'(in_from_node), NB'(in_to_node)};
          dist_wd = CB'(in_value);
        end
        // depot heads every route
        rt_we = 1'b1; rt_wa = LB'(0); rt_wd = '0;
        visited_nxt = MAX_NODES'(1);
        total_nxt = '0;
        cnt_nxt = '0;
        cust_nxt = LB'(1);
      end
      ST_OPEN: begin
        // open route 0 -> cust
        len_nxt = LB'(2);
        last_nxt = cn;
        load_nxt = 13'(dem_r[cn]);
        found_nxt = 1'b0;
        pv_nxt = 1'b0;
        j_nxt = LB'(1);
        if (open_go) begin
          visited_nxt[cn] = 1'b1;
          rt_we = 1'b1; rt_wa = LB'(1); rt_wd = cn;
        end
        if (cust_r < n_eff) cust_nxt = cust_r + LB'(1);
      end
      ST_SCAN, ST_SCAN_LAST: begin
        // evaluate candidate read in the previous cycle
        if (pv_r && dist_rd != '0 && (!found_r || dist_rd < bestd_r)) begin
          found_nxt = 1'b1; bestd_nxt = dist_rd; best_nxt = pj_r;
        end
        if (state_r == ST_SCAN) begin
          dist_ra = {last_r, jn};
          pj_nxt = jn;
          pv_nxt = cand_ok && j_r < n_eff;
          j_nxt = j_r + LB'(1);
        end else begin
          pv_nxt = 1'b0;
        end
      end
      ST_APPEND: begin
        if (found_r && len_r < MAXN_L) begin
          rt_we = 1'b1; rt_wa = len_r; rt_wd = best_r;
          len_nxt = len_r + LB'(1);
          visited_nxt[best_r] = 1'b1;
          load_nxt = load_r + 13'(dem_r[best_r]);
          last_nxt = best_r;
        end
        found_nxt = 1'b0; pv_nxt = 1'b0; j_nxt = LB'(1);
      end
      ST_CLOSE: begin
        // append depot, start cost walk
        rt_we = 1'b1; rt_wa = len_r; rt_wd = '0;
        len_nxt = len_r + LB'(1);
        rt_ra = LB'(1);
        dist_ra = {NB'(0), NB'(0)};
        prev_nxt = '0;
        k_nxt = LB'(1);
        rcost_nxt = '0; ok_nxt = 1'b1;
        pv_nxt = 1'b0;
      end
      ST_COST, ST_COST_LAST: begin
        // route_rd holds node k read last cycle; pv marks a pending edge
        if (pv_r) begin
          if (dist_rd == '0) ok_nxt = 1'b0;
          rcost_nxt = radd[SUM_BITS] ? SUM_MAX : radd[SUM_BITS-1:0];
        end
        if (state_r == ST_COST) begin
          dist_ra = {prev_r, route_rd};
          prev_nxt = route_rd;
          pv_nxt = 1'b1;
          rt_ra = k_r + LB'(1);
          k_nxt = k_r + LB'(1);
        end else begin
          pv_nxt = 1'b0;
          k_nxt = '0;
          rt_ra = '0;
        end
      end
      ST_EMIT: begin
        // route_rd holds node k
        rt_ra = k_r;
        if (o_free && !emit_stop) begin
          o_load = 1'b1;
          o_node = 4'(route_rd);
          o_re = (k_r == len_r - LB'(1));
          o_rc = o_re ? rcost_r : '0;
          cnt_nxt = cnt_r + RB'(1);
          k_nxt = k_r + LB'(1);
          rt_ra = k_r + LB'(1);
        end
      end
      ST_TOTAL: begin
        if (o_free) begin
          o_load = 1'b1; o_it = 1'b1; o_tc = total_r;
        end
      end
      ST_DONE: ;
      default: ;
    endcase

    // kept route: add its cost to the total when the walk ends
    if (state_r == ST_COST_LAST && ok_nxt) begin
      total_nxt = ((SUM_BITS+1)'(total_r) + (SUM_BITS+1)'(rcost_nxt) > (SUM_BITS+1)'(SUM_MAX))
                  ? SUM_MAX : total_r + rcost_nxt;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      clr_r   <= '0;
      visited_r <= '0;
      len_r <= '0; total_r <= '0; cnt_r <= '0;
      found_r <= 1'b0; pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_busy) clr_r <= clr_r + (AB+1)'(1);
      visited_r <= visited_nxt;
      len_r <= len_nxt; total_r <= total_nxt; cnt_r <= cnt_nxt;
      found_r <= found_nxt; pv_r <= pv_nxt;
      if (o_load)        ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    cust_r <= cust_nxt; j_r <= j_nxt; k_r <= k_nxt; last_r <= last_nxt;
    load_r <= load_nxt; best_r <= best_nxt; bestd_r <= bestd_nxt;
    pj_r <= pj_nxt; rcost_r <= rcost_nxt; ok_r <= ok_nxt; prev_r <= prev_nxt;
    if (o_load) begin
      on_r <= o_node; orc_r <= o_rc; ore_r <= o_re; otc_r <= o_tc; oit_r <= o_it;
    end
  end

  assign out_valid      = ov_r;
  assign out_node       = on_r;
  assign out_route_cost = orc_r;
  assign out_route_end  = ore_r;
  assign out_total_cost = otc_r;
  assign out_is_total   = oit_r;

`ifndef SYNTHESIS
  // no input beat while the matrix is being cleared
  a_no_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready) else $error("input taken during clear");
  // a pending beat is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |-> !o_load) else $error("output overwritten");
  // route length never exceeds the buffer
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LB'(MAX_NODES + 1)) else $error("route overflow");
  // the depot is always visited during a run
  a_depot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> visited_r[0]) else $error("depot not visited");
`endif

endmodule
